// ----- rtl/core/sgm_pkg.sv -----
// Shared types and constants for the Sobel gradient magnitude unit.
package sgm_pkg;

  localparam int LANES      = 4;
  localparam int PIX_W      = 8 * LANES;
  localparam int WIN_TAPS   = 9;
  localparam int COL_W      = 10;
  localparam int ROW_W      = 16;
  localparam int IMG_W_BITS = 11;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int LANE_LAT   = 5;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  localparam logic [IMG_W_BITS-1:0] IMAGE_WIDTH_RST  = 11'd1024;
  localparam logic [ROW_W-1:0]      IMAGE_HEIGHT_RST = 16'd480;

  typedef struct packed {
    logic [7:0] chan0_in;
    logic [7:0] chan1_in;
    logic [7:0] chan2_in;
    logic [7:0] chan3_in;
  } sgm_in_t;

  typedef struct packed {
    logic [7:0]       chan0_mag;
    logic [7:0]       chan1_mag;
    logic [7:0]       chan2_mag;
    logic [7:0]       chan3_mag;
    logic [COL_W-1:0] pixel_col;
    logic [ROW_W-1:0] pixel_row;
    logic             frame_last;
  } sgm_out_t;

  typedef struct packed {
    logic             valid;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             last;
  } sgm_meta_t;

  typedef logic [WIN_TAPS-1:0][PIX_W-1:0] sgm_win_t;
  typedef logic [WIN_TAPS-1:0][7:0]       sgm_lane_win_t;

endpackage

// ----- rtl/core/sgm_line_window.sv -----
// Raster counters, two line memories and the 3x3 pixel window.
module sgm_line_window #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               adv,
  input  logic                               accept,
  input  logic [sgm_pkg::PIX_W-1:0]          pix,
  input  logic [sgm_pkg::IMG_W_BITS-1:0]     image_width,
  input  logic [sgm_pkg::ROW_W-1:0]          image_height,
  output sgm_pkg::sgm_win_t                  win,
  output sgm_pkg::sgm_meta_t                 meta
);
  import sgm_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = (CW + 1 > IMG_W_BITS) ? CW + 1 : IMG_W_BITS;
  localparam int PW = (CW > COL_W) ? CW : COL_W;

  logic [PIX_W-1:0] mem_up  [MAX_WIDTH];
  logic [PIX_W-1:0] mem_mid [MAX_WIDTH];

  logic [CW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;

  logic             s1_valid_r;
  logic [PIX_W-1:0] s1_pix_r;
  logic [CW-1:0]    s1_idx_r;
  sgm_meta_t        s1_meta_r, s1_meta_nxt;
  logic [PIX_W-1:0] rd_up_r, rd_mid_r;
  logic             fwd_r;
  logic [PIX_W-1:0] fwd_up_r, fwd_mid_r;

  sgm_win_t         win_r, win_nxt;
  sgm_meta_t        s2_meta_r;

  logic [WW-1:0]    w_ext, w_eff, col_ext, col_inc;
  logic [ROW_W:0]   row_inc, h_ext;
  logic [PW-1:0]    col_less;
  logic [PIX_W-1:0] up_eff, mid_eff;

  always_comb begin
    w_ext   = WW'(image_width);
    w_eff   = (w_ext > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : w_ext;
    col_ext = WW'(col_r);
    col_inc = col_ext + WW'(1);
    row_inc = {1'b0, row_r} + 17'd1;
    h_ext   = {1'b0, image_height};
    col_less = PW'(col_r) - PW'(1);

    s1_meta_nxt.valid = (row_r >= 16'd2) && (col_r >= CW'(2)) && (col_ext < w_eff) &&
                        (row_r < image_height);
    s1_meta_nxt.col   = col_less[COL_W-1:0];
    s1_meta_nxt.row   = row_r - 16'd1;
    s1_meta_nxt.last  = (row_inc == h_ext) && (col_inc == w_eff);

    if (col_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = (row_inc >= h_ext) ? '0 : row_inc[ROW_W-1:0];
    end else begin
      col_nxt = col_inc[CW-1:0];
      row_nxt = row_r;
    end
  end

  always_comb begin
    up_eff  = fwd_r ? fwd_up_r  : rd_up_r;
    mid_eff = fwd_r ? fwd_mid_r : rd_mid_r;
    win_nxt = win_r;
    win_nxt[0] = win_r[1];
    win_nxt[1] = win_r[2];
    win_nxt[2] = up_eff;
    win_nxt[3] = win_r[4];
    win_nxt[4] = win_r[5];
    win_nxt[5] = mid_eff;
    win_nxt[6] = win_r[7];
    win_nxt[7] = win_r[8];
    win_nxt[8] = s1_pix_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
      win_r      <= '0;
      s2_meta_r  <= '0;
    end else if (adv) begin
      s1_valid_r <= accept;
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
        fwd_r <= s1_valid_r && (s1_idx_r == col_r);
      end
      if (s1_valid_r) begin
        win_r <= win_nxt;
      end
      s2_meta_r <= '{valid: s1_valid_r && s1_meta_r.valid, col: s1_meta_r.col,
                     row: s1_meta_r.row, last: s1_meta_r.last};
    end
  end

  always_ff @(posedge clk) begin
    if (adv && accept) begin
      s1_pix_r  <= pix;
      s1_idx_r  <= col_r;
      s1_meta_r <= s1_meta_nxt;
      rd_up_r   <= mem_up[col_r];
      rd_mid_r  <= mem_mid[col_r];
      fwd_up_r  <= mid_eff;
      fwd_mid_r <= s1_pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      mem_up[s1_idx_r]  <= mid_eff;
      mem_mid[s1_idx_r] <= s1_pix_r;
    end
  end

  assign win  = win_r;
  assign meta = s2_meta_r;

endmodule

// ----- rtl/core/sgm_lane.sv -----
// One byte lane: Sobel gradients, sum of squares and pipelined square root.
module sgm_lane (
  input  logic                       clk,
  input  logic                       adv,
  input  sgm_pkg::sgm_lane_win_t     win,
  output logic [7:0]                 mag
);
  import sgm_pkg::*;

  typedef struct packed {
    logic [15:0] rem;
    logic [15:0] root;
  } sqrt_t;

  function automatic sqrt_t sqrt_step(sqrt_t s, int unsigned sh);
    logic [15:0] b;
    logic [16:0] trial;
    sqrt_t       r;
    b     = 16'd1 << sh;
    trial = {1'b0, s.root} + {1'b0, b};
    r     = s;
    if ({1'b0, s.rem} >= trial) begin
      r.rem  = s.rem - trial[15:0];
      r.root = (s.root >> 1) + b;
    end else begin
      r.root = s.root >> 1;
    end
    return r;
  endfunction

  logic signed [10:0] p [WIN_TAPS];
  logic signed [10:0] gx, gy;
  logic signed [10:0] gx_r, gy_r;
  logic signed [21:0] sqx, sqy;
  logic [19:0]        sqx_r, sqy_r;
  logic [20:0]        sum;
  logic [15:0]        q_r;
  logic               sat_r, sat_a_r;
  sqrt_t              sa, sa_r, sb;
  logic [7:0]         mag_r;

  always_comb begin
    for (int k = 0; k < WIN_TAPS; k++) begin
      p[k] = signed'({3'b000, win[k]});
    end
    gx  = p[0] + (p[1] <<< 1) + p[2] - p[6] - (p[7] <<< 1) - p[8];
    gy  = p[0] - p[2] + (p[3] <<< 1) - (p[5] <<< 1) + p[6] - p[8];
    sqx = gx_r * gx_r;
    sqy = gy_r * gy_r;
    sum = {1'b0, sqx_r} + {1'b0, sqy_r};
    sa  = '{rem: q_r, root: 16'd0};
    for (int k = 0; k < 4; k++) begin
      sa = sqrt_step(sa, 14 - 2 * k);
    end
    sb = sa_r;
    for (int k = 0; k < 4; k++) begin
      sb = sqrt_step(sb, 6 - 2 * k);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      gx_r    <= gx;
      gy_r    <= gy;
      sqx_r   <= sqx[19:0];
      sqy_r   <= sqy[19:0];
      q_r     <= sum[17:2];
      sat_r   <= |sum[20:18];
      sa_r    <= sa;
      sat_a_r <= sat_r;
      mag_r   <= sat_a_r ? 8'hFF : sb.root[7:0];
    end
  end

  assign mag = mag_r;

endmodule

// ----- rtl/core/sobel_gradient_magnitude_rgba_unit.sv -----
// Top level of the four-lane Sobel gradient magnitude unit.
// Usage:
//   Pixels enter on in_valid/in_ready in raster order, four byte lanes per
//   request. Each interior pixel yields one request on out_valid/out_ready with
//   the halved, saturated gradient magnitude per lane, the centre coordinates
//   and a frame_last flag; border pixels yield nothing.
//   Throughput: one pixel per clock while out_ready is high.
//   Pipeline: each request passes eight registers (line memory read at acceptance,
//   window, gradients, squares, sum, two square root stages of four steps,
//   output register); each window is centred one row and one column behind
//   the input.
//   The pipeline advances as a whole: when out_valid is high and out_ready low
//   every stage holds and in_ready drops until the result is taken.
//   Reset (synchronous, rst_n low) clears the counters, window and valid bits
//   and loads width 1024, height 480. Line memories need no clearing pass.
//   cfg_we writes image_width (index 0) or image_height (index 1);
//   write only while the pipeline is empty.
module sobel_gradient_magnitude_rgba_unit #(
  parameter int MAX_WIDTH = 1024,
  parameter int CHANNELS  = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  sgm_pkg::sgm_in_t                   in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output sgm_pkg::sgm_out_t                  out_data,
  input  logic                               cfg_we,
  input  logic [sgm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sgm_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import sgm_pkg::*;

  logic [IMG_W_BITS-1:0] image_width_r;
  logic [ROW_W-1:0]      image_height_r;
  logic                  adv, accept;
  logic [PIX_W-1:0]      raw_pix, pix;
  sgm_win_t              win;
  sgm_meta_t             s2_meta;
  sgm_meta_t             meta_r [LANE_LAT];
  logic [LANES-1:0][7:0] mag;
  logic                  out_valid_r;
  sgm_out_t              out_data_r, out_data_nxt;

  assign adv      = !out_valid_r || out_ready;
  assign accept   = in_valid && adv;
  assign in_ready = adv;
  assign raw_pix  = {in_data.chan3_in, in_data.chan2_in, in_data.chan1_in, in_data.chan0_in};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= IMAGE_WIDTH_RST;
      image_height_r <= IMAGE_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width_r  <= cfg_data[IMG_W_BITS-1:0];
        REG_IMAGE_HEIGHT: image_height_r <= cfg_data[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  sgm_line_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_window (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .accept       (accept),
    .pix          (pix),
    .image_width  (image_width_r),
    .image_height (image_height_r),
    .win          (win),
    .meta         (s2_meta)
  );

  for (genvar ch = 0; ch < LANES; ch++) begin : g_lane
    if (ch < CHANNELS) begin : g_on
      sgm_lane_win_t lane_win;
      assign pix[8*ch +: 8] = raw_pix[8*ch +: 8];
      for (genvar k = 0; k < WIN_TAPS; k++) begin : g_tap
        assign lane_win[k] = win[k][8*ch +: 8];
      end
      sgm_lane u_lane (
        .clk (clk),
        .adv (adv),
        .win (lane_win),
        .mag (mag[ch])
      );
    end else begin : g_off
      assign pix[8*ch +: 8] = 8'd0;
      assign mag[ch]        = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LANE_LAT; i++) begin
        meta_r[i] <= '0;
      end
      out_valid_r <= 1'b0;
    end else if (adv) begin
      meta_r[0] <= s2_meta;
      for (int i = 1; i < LANE_LAT; i++) begin
        meta_r[i] <= meta_r[i-1];
      end
      out_valid_r <= meta_r[LANE_LAT-1].valid;
    end
  end

  always_comb begin
    out_data_nxt.chan0_mag  = mag[0];
    out_data_nxt.chan1_mag  = mag[1];
    out_data_nxt.chan2_mag  = mag[2];
    out_data_nxt.chan3_mag  = mag[3];
    out_data_nxt.pixel_col  = meta_r[LANE_LAT-1].col;
    out_data_nxt.pixel_row  = meta_r[LANE_LAT-1].row;
    out_data_nxt.frame_last = meta_r[LANE_LAT-1].last;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/core/sgm_checker.sv -----
// Port-level checks for the Sobel gradient magnitude unit, bound to the top.
module sgm_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input sgm_pkg::sgm_out_t  out_data
);
  import sgm_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result request changed while stalled");

  a_stall_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  a_row_interior: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.pixel_row != 16'd0)
    else $error("result on a border row");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind sobel_gradient_magnitude_rgba_unit sgm_checker u_sgm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- verif/tb.sv -----
// Testbench for the Sobel gradient magnitude unit: predicts and checks each result request.
`timescale 1ns / 1ps

module tb;
  import sgm_pkg::*;

  localparam int MAX_W         = 1024;
  localparam int SETTLE_CYCLES = 16;
  localparam int LONG_HOLD     = 400;
  localparam int IDLE_LIMIT    = 4000;
  localparam int ITEM_BUDGET   = 950;

  typedef logic [LANES-1:0][7:0] lane_vec_t;
  typedef enum int {PIX_NOISE, PIX_BINARY, PIX_DIM} pix_style_t;
  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BURSTY} rx_mode_t;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  sgm_in_t               in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  sgm_out_t              out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // predictor state
  lane_vec_t       upper_row [MAX_W]    = '{default: '0};
  lane_vec_t       middle_row [MAX_W]   = '{default: '0};
  lane_vec_t       win [WIN_TAPS]       = '{default: '0};
  int unsigned     col_cnt              = 0;
  int unsigned     row_cnt              = 0;
  logic [10:0]     width_reg            = IMAGE_WIDTH_RST;
  logic [15:0]     height_reg           = IMAGE_HEIGHT_RST;
  sgm_out_t        expected_mags [$];

  int unsigned     mismatch_count = 0;
  int unsigned     pixels_sent    = 0;
  int unsigned     burst_left     = 0;
  bit              steady_sender  = 1'b0;
  logic            hold_arm       = 1'b0;
  logic            hold_seen      = 1'b0;
  int unsigned     hold_left      = 0;
  rx_mode_t        rx_mode        = RX_OPEN;
  int unsigned     rx_mode_left   = 0;
  logic [2:0]      rx_tick        = '0;
  int unsigned     idle_cycles    = 0;

  sobel_gradient_magnitude_rgba_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic lane_vec_t unpack_lanes(sgm_in_t px);
    return {px.chan3_in, px.chan2_in, px.chan1_in, px.chan0_in};
  endfunction

  function automatic int unsigned floor_root(int unsigned n);
    int unsigned r;
    int unsigned trial;
    r = 0;
    for (int b = 11; b >= 0; b--) begin
      trial = r | (32'd1 << b);
      if (trial * trial <= n) r = trial;
    end
    return r;
  endfunction

  function automatic logic [7:0] lane_magnitude(int ln);
    int t [WIN_TAPS];
    int gx;
    int gy;
    int unsigned half;
    for (int k = 0; k < WIN_TAPS; k++) t[k] = int'(win[k][ln]);
    gx = t[0] + 2 * t[1] + t[2] - t[6] - 2 * t[7] - t[8];
    gy = t[0] - t[2] + 2 * t[3] - 2 * t[5] + t[6] - t[8];
    half = floor_root(gx * gx + gy * gy) >> 1;
    return (half > 255) ? 8'hFF : half[7:0];
  endfunction

  // shift one raster pixel into the window and line stores; queue a result if interior
  function automatic void advance_raster(sgm_in_t px);
    lane_vec_t   pv;
    int unsigned w;
    int unsigned idx;
    sgm_out_t    mag;
    pv  = unpack_lanes(px);
    w   = (width_reg > MAX_W) ? MAX_W : width_reg;
    idx = (col_cnt < MAX_W) ? col_cnt : MAX_W - 1;
    for (int r = 0; r < 3; r++) begin
      win[3 * r]     = win[3 * r + 1];
      win[3 * r + 1] = win[3 * r + 2];
    end
    win[2] = upper_row[idx];
    win[5] = middle_row[idx];
    win[8] = pv;
    upper_row[idx]  = middle_row[idx];
    middle_row[idx] = pv;
    if (row_cnt >= 2 && col_cnt >= 2 && col_cnt < w && row_cnt < height_reg) begin
      mag.chan0_mag  = lane_magnitude(0);
      mag.chan1_mag  = lane_magnitude(1);
      mag.chan2_mag  = lane_magnitude(2);
      mag.chan3_mag  = lane_magnitude(3);
      mag.pixel_col  = COL_W'(col_cnt - 1);
      mag.pixel_row  = ROW_W'(row_cnt - 1);
      mag.frame_last = (row_cnt + 1 == height_reg) && (col_cnt + 1 == w);
      expected_mags = {expected_mags, mag};
    end
    if (col_cnt + 1 >= w) begin
      col_cnt = 0;
      row_cnt = (row_cnt + 1 >= height_reg) ? 0 : row_cnt + 1;
    end else begin
      col_cnt = col_cnt + 1;
    end
  endfunction

  function automatic sgm_in_t rand_pixel(pix_style_t style);
    logic [PIX_W-1:0] bits;
    bits = $urandom;
    case (style)
      PIX_BINARY: begin
        for (int k = 0; k < LANES; k++) bits[8 * k +: 8] = bits[8 * k] ? 8'hFF : 8'h00;
      end
      PIX_DIM: begin
        bits = bits & 32'h0F0F0F0F;
      end
      default: ;
    endcase
    return sgm_in_t'(bits);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    $display("tb: mismatch on %s: got %0d, expected %0d", what, got, want);
  endtask

  task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic send_pixel(sgm_in_t px);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = steady_sender ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (!in_ready);
    advance_raster(px);
    pixels_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_mags.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_geometry(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    width_reg = w[10:0];
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    height_reg = h;
    cfg_we <= 1'b0;
  endtask

  task automatic complete_frame(pix_style_t style);
    while (col_cnt != 0 || row_cnt != 0) send_pixel(rand_pixel(style));
  endtask

  task automatic test_value_extremes();
    logic [PIX_W-1:0] pat [9];
    sgm_in_t          px;
    set_geometry(3, 3);
    for (int k = 0; k < 9; k++) send_pixel(sgm_in_t'((k < 3) ? 32'hFFFFFFFF : 32'h0));
    pat = '{32'hFFFF00FF, 32'h00FF0100, 32'h00FF00FF, 32'h00FF0000, 32'h00FF00FF,
            32'h00FF0000, 32'h00FF00FF, 32'h00FF0000, 32'h00FF00FF};
    for (int k = 0; k < 9; k++) send_pixel(sgm_in_t'(pat[k]));
    // signed gradients: bright bottom row (negative gx), bright left column (positive gy)
    for (int k = 0; k < 9; k++) begin
      px = '0;
      if (k / 3 == 2) begin
        px.chan0_in = 8'hFF;
        px.chan1_in = 8'hFF;
      end
      if (k % 3 == 0) begin
        px.chan2_in = 8'hFF;
        px.chan3_in = 8'h40;
      end
      send_pixel(px);
    end
  endtask

  task automatic test_degenerate_sizes();
    set_geometry(2, 5);
    repeat (12) send_pixel(rand_pixel(PIX_NOISE));
    complete_frame(PIX_NOISE);
    set_geometry(0, 4);
    repeat (6) send_pixel(rand_pixel(PIX_NOISE));
    complete_frame(PIX_NOISE);
    set_geometry(1, 0);
    repeat (5) send_pixel(rand_pixel(PIX_NOISE));
    complete_frame(PIX_NOISE);
    set_geometry(6, 2);
    repeat (9) send_pixel(rand_pixel(PIX_NOISE));
    complete_frame(PIX_NOISE);
    set_geometry(4, 1);
    repeat (7) send_pixel(rand_pixel(PIX_NOISE));
    complete_frame(PIX_NOISE);
  endtask

  task automatic test_midframe_writes();
    set_geometry(10, 8);
    repeat (37) send_pixel(rand_pixel(PIX_NOISE));
    // counters now sit past the new last column and row
    set_geometry(5, 3);
    complete_frame(PIX_NOISE);
    set_geometry(12, 6);
    repeat (29) send_pixel(rand_pixel(PIX_NOISE));
    set_geometry(8, 16'hFFFF);
    repeat (48) send_pixel(rand_pixel(PIX_BINARY));
    set_geometry(8, 4);
    complete_frame(PIX_NOISE);
  endtask

  task automatic test_config_masking();
    // data bits above the width register are dropped: reads as width 3
    set_geometry(16'hF803, 3);
    repeat (18) send_pixel(rand_pixel(PIX_NOISE));
  endtask

  task automatic test_output_stall();
    set_geometry(16, 12);
    steady_sender = 1'b1;
    hold_arm <= ~hold_arm;
    repeat (16 * 12) send_pixel(rand_pixel(PIX_NOISE));
    steady_sender = 1'b0;
  endtask

  task automatic test_random_frames();
    int unsigned w;
    int unsigned h;
    int unsigned n;
    pix_style_t  style;
    while (pixels_sent < ITEM_BUDGET) begin
      case ($urandom_range(0, 19))
        0:          w = $urandom_range(41, 64);
        1, 2, 3, 4: w = $urandom_range(13, 40);
        default:    w = $urandom_range(3, 12);
      endcase
      h = $urandom_range(3, (w > 40) ? 5 : 10);
      set_geometry(CFG_DATA_W'(w), CFG_DATA_W'(h));
      style = pix_style_t'($urandom_range(0, 2));
      steady_sender = ($urandom_range(0, 3) == 0);
      n = $urandom_range(1, 2 * w * h);
      if (n > ITEM_BUDGET - pixels_sent) n = ITEM_BUDGET - pixels_sent;
      repeat (n) send_pixel(rand_pixel(style));
      complete_frame(style);
    end
    steady_sender = 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready    <= 1'b0;
      hold_left    <= 0;
      rx_mode_left <= 0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_arm != hold_seen) begin
      hold_seen <= hold_arm;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else begin
      rx_tick <= rx_tick + 1'b1;
      if (rx_mode_left == 0) begin
        rx_mode      <= rx_mode_t'($urandom_range(0, 3));
        rx_mode_left <= $urandom_range(20, 200);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_COIN:   out_ready <= $urandom_range(0, 1);
        RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default:   out_ready <= (rx_tick < 3'd3);
      endcase
    end
  end

  always @(posedge clk) begin : check_results
    sgm_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_mags.size() == 0) begin
        report_mismatch("unrequested result, pixel_col", out_data.pixel_col, 0);
      end else begin
        want = expected_mags.pop_front();
        check_field("chan0_mag", out_data.chan0_mag, want.chan0_mag);
        check_field("chan1_mag", out_data.chan1_mag, want.chan1_mag);
        check_field("chan2_mag", out_data.chan2_mag, want.chan2_mag);
        check_field("chan3_mag", out_data.chan3_mag, want.chan3_mag);
        check_field("pixel_col", out_data.pixel_col, want.pixel_col);
        check_field("pixel_row", out_data.pixel_row, want.pixel_row);
        check_field("frame_last", out_data.frame_last, want.frame_last);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_value_extremes();
    test_degenerate_sizes();
    test_midframe_writes();
    test_config_masking();
    test_output_stall();
    test_random_frames();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
